// ----- rtl/bra_pkg.sv -----
// Shared constants, request codes and interface structs for the bitmap run allocator.
// No dependencies; every other file in rtl/ imports this package.
package bra_pkg;

   localparam int MAP_BYTES  = 128;
   localparam int MAP_ADDR_W = $clog2(MAP_BYTES);
   localparam int BYTE_BITS  = 8;
   localparam int BIT_SEL_W  = $clog2(BYTE_BITS);
   localparam int BIT_IDX_W  = 10;
   localparam int RUN_W      = 11;
   localparam int USED_W     = $clog2(MAP_BYTES + 1);
   localparam int TOTAL_W    = USED_W + BIT_SEL_W;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_WORD_LSB = 2;

   localparam logic [CSR_ADDR_W-CSR_WORD_LSB-1:0] REG_BYTES_IN_USE = '0;
   localparam logic [USED_W-1:0] BYTES_IN_USE_RESET = USED_W'(MAP_BYTES);

   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_TEST  = 2'd1,
      REQ_WRITE = 2'd2,
      REQ_SCAN  = 2'd3
   } req_code_type;

   // Memory command from the sequencer to the map store.
   typedef struct packed {
      logic                  rd_en;
      logic [MAP_ADDR_W-1:0] rd_addr;
      logic                  wr_en;
      logic [MAP_ADDR_W-1:0] wr_addr;
      logic [BYTE_BITS-1:0]  wr_data;
      logic                  clr;
   } map_cmd_type;

   // Outcome of scanning one map byte.
   typedef struct packed {
      logic                 hit;
      logic [BIT_SEL_W-1:0] hit_bit;
      logic [RUN_W-1:0]     run_out;
   } scan_res_type;

endpackage

// ----- rtl/bitmap_run_allocator_core.sv -----
// Top level of the first-fit bitmap run allocator: request sequencer and result register.
// Depends on bra_pkg, bra_csr, bra_map_mem and bra_byte_scan.
//
// Usage:
//  - Request channel: drive req_* and raise start; the request is taken at the
//    clock edge where start is high and busy is low. busy stays high until the
//    cycle that shows the result beat.
//  - Result channel: rsp_strobe is high for exactly one cycle with rsp_found,
//    rsp_run_start and rsp_tested_bit; the receiver cannot stall it, so the
//    beat must be taken on that cycle.
//  - Steps after the accepting edge: clear, out-of-range test or write and
//    hopeless scan answer from S_EXEC; an in-range test or write reads its
//    byte in S_EXEC and answers from S_WAIT, where a write stores it back;
//    a scan reads in S_EXEC, then stays in S_SCAN until a hit or the last
//    byte in use. The map RAM gives one byte per cycle, and that read port
//    sets the scan rate. A new request may be presented in the strobe cycle.
//  - Configuration: bytes_in_use at byte address 0, written while idle.
//  - Reset (synchronous): the map reads as all free at once (per-byte valid
//    bits), bytes_in_use returns to 128, the sequencer goes idle; no clearing
//    pass is needed.
module bitmap_run_allocator_core (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_type,
   input  logic [bra_pkg::BIT_IDX_W-1:0]  req_bit_index,
   input  logic                           req_bit_value,
   input  logic [bra_pkg::RUN_W-1:0]      req_run_length,
   // result channel
   output logic                           rsp_strobe,
   output logic                           rsp_found,
   output logic [bra_pkg::BIT_IDX_W-1:0]  rsp_run_start,
   output logic                           rsp_tested_bit,
   // configuration port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bra_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bra_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bra_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import bra_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_WAIT,
      S_SCAN
   } state_type;

   state_type             state_ff;
   req_code_type          type_ff;
   logic [BIT_IDX_W-1:0]  idx_ff;
   logic                  val_ff;
   logic [RUN_W-1:0]      len_ff;
   logic [MAP_ADDR_W-1:0] byte_ff;
   logic [RUN_W-1:0]      run_ff;
   logic                  strobe_ff;
   logic                  found_ff;
   logic [BIT_IDX_W-1:0]  start_ff;
   logic                  tested_ff;

   logic [USED_W-1:0]     used_bytes;
   logic [TOTAL_W-1:0]    total_bits;
   logic                  in_range;
   logic                  scan_ok;
   logic                  last_byte;
   logic [MAP_ADDR_W-1:0] rd_byte;
   logic [BIT_SEL_W-1:0]  bit_sel;
   logic [BYTE_BITS-1:0]  bit_mask;
   logic [BYTE_BITS-1:0]  rd_data;
   logic [RUN_W-1:0]      hit_pos;
   map_cmd_type           cmd;
   scan_res_type          scan;

   bra_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .used_bytes (used_bytes)
   );

   bra_map_mem u_mem (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .used_bytes (used_bytes),
      .rd_data    (rd_data)
   );

   bra_byte_scan u_scan (
      .data   (rd_data),
      .run_in (run_ff),
      .want   (len_ff),
      .res    (scan)
   );

   // Bits under management; tests and writes at or past this are out of range.
   assign total_bits = {used_bytes, BIT_SEL_W'(0)};
   assign in_range   = (TOTAL_W'(idx_ff) < total_bits);
   // A zero length or a run longer than the managed map can never be found.
   assign scan_ok    = (len_ff != '0) && (TOTAL_W'(len_ff) <= total_bits);
   assign last_byte  = ((USED_W'(byte_ff) + USED_W'(1)) == used_bytes);

   assign rd_byte  = idx_ff[BIT_IDX_W-1:BIT_SEL_W];
   assign bit_sel  = idx_ff[BIT_SEL_W-1:0];
   assign bit_mask = BYTE_BITS'(1) << bit_sel;
   // Start of the run that ends at the hit bit, taken to the index width.
   assign hit_pos  = RUN_W'({byte_ff, scan.hit_bit}) + RUN_W'(1) - len_ff;

   // Drive the map store from the sequencer state.
   always_comb begin
      cmd = '0;
      case (state_ff)
         S_EXEC: begin
            case (type_ff)
               REQ_CLEAR: cmd.clr = 1'b1;
               REQ_TEST, REQ_WRITE: begin
                  cmd.rd_en   = in_range;
                  cmd.rd_addr = rd_byte;
               end
               REQ_SCAN: begin
                  cmd.rd_en   = scan_ok;
                  cmd.rd_addr = '0;
               end
               default: cmd = '0;
            endcase
         end
         S_WAIT: begin
            // Write back the modified byte; no later access can reach it
            // before this edge, so no forwarding is needed.
            cmd.wr_en   = (type_ff == REQ_WRITE);
            cmd.wr_addr = rd_byte;
            cmd.wr_data = val_ff ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
         end
         S_SCAN: begin
            // Prefetch the next byte while the current one is counted.
            cmd.rd_en   = !last_byte;
            cmd.rd_addr = byte_ff + MAP_ADDR_W'(1);
         end
         default: cmd = '0;
      endcase
   end

   // Sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
         found_ff  <= 1'b0;
         start_ff  <= '0;
         tested_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  type_ff  <= req_code_type'(req_type);
                  idx_ff   <= req_bit_index;
                  val_ff   <= req_bit_value;
                  len_ff   <= req_run_length;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               byte_ff <= '0;
               run_ff  <= '0;
               if (((type_ff == REQ_TEST) || (type_ff == REQ_WRITE)) && in_range) begin
                  state_ff <= S_WAIT;
               end else if ((type_ff == REQ_SCAN) && scan_ok) begin
                  state_ff <= S_SCAN;
               end else begin
                  // Clear, out-of-range access or hopeless scan: answer now.
                  strobe_ff <= 1'b1;
                  found_ff  <= 1'b0;
                  start_ff  <= '0;
                  tested_ff <= 1'b0;
                  state_ff  <= S_IDLE;
               end
            end
            S_WAIT: begin
               strobe_ff <= 1'b1;
               found_ff  <= 1'b0;
               start_ff  <= '0;
               tested_ff <= (type_ff == REQ_TEST) && rd_data[bit_sel];
               state_ff  <= S_IDLE;
            end
            S_SCAN: begin
               if (scan.hit || last_byte) begin
                  strobe_ff <= 1'b1;
                  found_ff  <= scan.hit;
                  start_ff  <= scan.hit ? hit_pos[BIT_IDX_W-1:0] : '0;
                  tested_ff <= 1'b0;
                  state_ff  <= S_IDLE;
               end else begin
                  byte_ff <= byte_ff + MAP_ADDR_W'(1);
                  run_ff  <= scan.run_out;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_found      = found_ff;
   assign rsp_run_start  = start_ff;
   assign rsp_tested_bit = tested_ff;

   // An accepted request always keeps the block busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not make the block busy");

   // A result beat ends the request: the block is idle afterwards.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat shown while still busy");

   // A found run lies wholly inside the managed bits.
   a_run_inside: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_found) |->
         ((TOTAL_W + 1)'(rsp_run_start) + (TOTAL_W + 1)'(len_ff) <=
          (TOTAL_W + 1)'(total_bits)))
      else $error("found run extends past the managed map");

   // Only scans report a run, only tests report a bit.
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_found && rsp_tested_bit))
      else $error("result reports both a run and a tested bit");

endmodule

// ----- rtl/bra_map_mem.sv -----
// Allocation map store: one synchronous byte RAM plus a valid bit per byte.
// Depends on bra_pkg. Invalid bytes read as zero, so reset and clear are immediate.
module bra_map_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  bra_pkg::map_cmd_type          cmd,
   input  logic [bra_pkg::USED_W-1:0]    used_bytes,
   output logic [bra_pkg::BYTE_BITS-1:0] rd_data
);
   import bra_pkg::*;

   logic [BYTE_BITS-1:0] mem [MAP_BYTES];
   logic [MAP_BYTES-1:0] valid_ff;
   logic [BYTE_BITS-1:0] data_ff;
   logic                 vld_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         data_ff <= mem[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (cmd.rd_en) begin
         vld_ff <= valid_ff[cmd.rd_addr];
      end
   end

   // Clear drops the valid bits of the bytes in use only.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < MAP_BYTES; i++) begin
            if (cmd.clr && (USED_W'(i) < used_bytes)) begin
               valid_ff[i] <= 1'b0;
            end else if (cmd.wr_en && (cmd.wr_addr == MAP_ADDR_W'(i))) begin
               valid_ff[i] <= 1'b1;
            end
         end
      end
   end

   assign rd_data = vld_ff ? data_ff : '0;

endmodule

// ----- rtl/bra_byte_scan.sv -----
// Run counter over the eight bits of one map byte, lowest bit first.
// Depends on bra_pkg.
module bra_byte_scan (
   input  logic [bra_pkg::BYTE_BITS-1:0] data,
   input  logic [bra_pkg::RUN_W-1:0]     run_in,
   input  logic [bra_pkg::RUN_W-1:0]     want,
   output bra_pkg::scan_res_type         res
);
   import bra_pkg::*;

   logic [RUN_W-1:0]     run;
   logic                 hit;
   logic [BIT_SEL_W-1:0] hit_bit;

   always_comb begin
      run     = run_in;
      hit     = 1'b0;
      hit_bit = '0;
      for (int k = 0; k < BYTE_BITS; k++) begin
         if (!hit) begin
            if (data[k]) begin
               run = '0;
            end else begin
               run = run + RUN_W'(1);
               if (run == want) begin
                  hit     = 1'b1;
                  hit_bit = BIT_SEL_W'(k);
               end
            end
         end
      end
      res.hit     = hit;
      res.hit_bit = hit_bit;
      res.run_out = run;
   end

endmodule

// ----- rtl/bra_csr.sv -----
// Configuration register file: bytes_in_use behind an APB-style port.
// Depends on bra_pkg. Also gives the byte count capped at the map size.
module bra_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bra_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bra_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bra_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output logic [bra_pkg::USED_W-1:0]     used_bytes
);
   import bra_pkg::*;

   logic [BYTE_BITS-1:0] bytes_in_use_ff;
   logic                 sel_reg;

   assign sel_reg = (paddr[CSR_ADDR_W-1:CSR_WORD_LSB] == REG_BYTES_IN_USE);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_in_use_ff <= BYTE_BITS'(MAP_BYTES);
      end else if (psel && penable && pwrite && sel_reg) begin
         bytes_in_use_ff <= pwdata[BYTE_BITS-1:0];
      end
   end

   assign prdata = sel_reg ? CSR_DATA_W'(bytes_in_use_ff) : '0;

   // Saturate at the physical map size.
   assign used_bytes = ({1'b0, bytes_in_use_ff} > (BYTE_BITS+1)'(MAP_BYTES)) ?
                       BYTES_IN_USE_RESET : USED_W'(bytes_in_use_ff);

endmodule

// ----- dv/bitmap_run_allocator_core_tb.sv -----
// Self-checking bench for bitmap_run_allocator_core: clear, test, write and first-fit scan
// requests checked against an in-bench model of the allocation map. Depends on bra_pkg and bitmap_run_allocator_core.
`timescale 1ns / 100ps

module bitmap_run_allocator_core_tb;
   import bra_pkg::*;

   // CSR map: bytes_in_use sits in word 0; the next word decodes to nothing
   localparam logic [CSR_ADDR_W-1:0] BIU_ADDR      = CSR_ADDR_W'(REG_BYTES_IN_USE) << CSR_WORD_LSB;
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR = BIU_ADDR + CSR_ADDR_W'(1 << CSR_WORD_LSB);
   localparam int MAX_GAP       = 11;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 4000;
   localparam int MAX_REPORTS   = 40;

   // one expected result beat, tagged with the request that caused it
   typedef struct packed {
      req_code_type          kind;
      logic                  found;
      logic [BIT_IDX_W-1:0]  run_start;
      logic                  tested_bit;
   } map_outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_type = REQ_CLEAR;
   logic [BIT_IDX_W-1:0]  req_bit_index = '0;
   logic                  req_bit_value = 1'b0;
   logic [RUN_W-1:0]      req_run_length = '0;
   logic                  rsp_strobe;
   logic                  rsp_found;
   logic [BIT_IDX_W-1:0]  rsp_run_start;
   logic                  rsp_tested_bit;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // shadow of the allocation map and of bytes_in_use, as the block should hold them
   logic [BYTE_BITS-1:0]  shadow_map [MAP_BYTES];
   logic [7:0]            shadow_bytes_in_use = BYTES_IN_USE_RESET;

   map_outcome_type       outcomes_due [$];
   int unsigned           mismatch_count = 0;
   int unsigned           requests_sent  = 0;
   int unsigned           beats_checked  = 0;
   int unsigned           map_sizes_run  = 0;
   bit                    back_to_back   = 1'b0;

   bitmap_run_allocator_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_bit_index  (req_bit_index),
      .req_bit_value  (req_bit_value),
      .req_run_length (req_run_length),
      .rsp_strobe     (rsp_strobe),
      .rsp_found      (rsp_found),
      .rsp_run_start  (rsp_run_start),
      .rsp_tested_bit (rsp_tested_bit),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_REPORTS)
         $display("MISMATCH @%0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Number of managed units: the register saturates at the map size.
   function automatic int unsigned units_in_use();
      return (shadow_bytes_in_use < MAP_BYTES ? shadow_bytes_in_use : MAP_BYTES) * BYTE_BITS;
   endfunction

   // Apply one request to the shadow map and return the beat it must produce.
   function automatic map_outcome_type apply_request_to_map(input req_code_type kind,
                                                           input logic [BIT_IDX_W-1:0] idx,
                                                           input logic val,
                                                           input logic [RUN_W-1:0] len);
      map_outcome_type outcome;
      int unsigned  units;
      int unsigned  pos;
      int unsigned  run;
      outcome = '{kind: kind, found: 1'b0, run_start: '0, tested_bit: 1'b0};
      units   = units_in_use();
      case (kind)
         REQ_CLEAR: begin
            // only the managed bytes are wiped; the rest keep their contents
            for (pos = 0; pos < units / BYTE_BITS; pos++)
               shadow_map[pos] = '0;
         end
         REQ_TEST: begin
            if (idx < units)
               outcome.tested_bit = shadow_map[idx / BYTE_BITS][idx % BYTE_BITS];
         end
         REQ_WRITE: begin
            if (idx < units)
               shadow_map[idx / BYTE_BITS][idx % BYTE_BITS] = val;
         end
         default: begin
            // first fit: hop over full bytes while no run is open, restart on a used bit
            if (len != 0 && len <= units) begin
               pos = 0;
               run = 0;
               while (pos < units && !outcome.found) begin
                  if (run == 0 && pos % BYTE_BITS == 0 && shadow_map[pos / BYTE_BITS] == 8'hff) begin
                     pos += BYTE_BITS;
                  end else begin
                     if (shadow_map[pos / BYTE_BITS][pos % BYTE_BITS] == 1'b0) begin
                        run++;
                        if (run == len) begin
                           outcome.found     = 1'b1;
                           outcome.run_start = BIT_IDX_W'(pos + 1 - len);
                        end
                     end else begin
                        run = 0;
                     end
                     pos++;
                  end
               end
            end
         end
      endcase
      return outcome;
   endfunction

   // Present one request and hold it until the block takes it. Entered and left just
   // after a rising edge; start is left high so a back-to-back beat needs no second drive.
   task automatic issue_request(input req_code_type kind, input logic [BIT_IDX_W-1:0] idx,
                                input logic val, input logic [RUN_W-1:0] len,
                                output map_outcome_type outcome);
      int unsigned gap;
      gap = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_type       <= kind;
      req_bit_index  <= idx;
      req_bit_value  <= val;
      req_run_length <= len;
      // busy only moves on a rising edge, so look at it on the falling edge
      @(negedge clock);
      while (busy !== 1'b0) @(negedge clock);
      outcome = apply_request_to_map(kind, idx, val, len);
      outcomes_due.push_back(outcome);
      requests_sent++;
      @(posedge clock);
   endtask

   // Drop start, let every outstanding beat come home, then allow the block to settle.
   task automatic wait_for_quiet();
      int unsigned spin;
      start <= 1'b0;
      spin = 0;
      while (outcomes_due.size() != 0 && spin < DRAIN_LIMIT) begin
         @(posedge clock);
         spin++;
      end
      if (outcomes_due.size() != 0) begin
         report_mismatch($sformatf("%0d result beats never arrived", outcomes_due.size()));
         outcomes_due.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Two-phase CSR write: setup cycle, then access cycle; pready is always high.
   // Hold the port idle after the access so writes never abut.
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == BIU_ADDR)
         shadow_bytes_in_use = data[7:0];
      @(posedge clock);
   endtask

   // Compare every result beat with the oldest outstanding expectation, mid-cycle.
   always @(negedge clock) begin : beat_check
      map_outcome_type want;
      if (reset === 1'b0 && rsp_strobe === 1'b1) begin
         if (outcomes_due.size() == 0) begin
            report_mismatch("result beat with no request outstanding");
         end else begin
            want = outcomes_due.pop_front();
            beats_checked++;
            if (rsp_found !== want.found)
               report_mismatch($sformatf("%s: found %b, want %b",
                                         want.kind.name(), rsp_found, want.found));
            if (rsp_run_start !== want.run_start)
               report_mismatch($sformatf("%s: run_start %0d, want %0d",
                                         want.kind.name(), rsp_run_start, want.run_start));
            if (rsp_tested_bit !== want.tested_bit)
               report_mismatch($sformatf("%s: tested_bit %b, want %b",
                                         want.kind.name(), rsp_tested_bit, want.tested_bit));
         end
      end
   end

   // Scan lengths: mostly modest, with zero, oversize and near-full-map lengths mixed in.
   function automatic logic [RUN_W-1:0] pick_run_length(input int unsigned units);
      int unsigned sel;
      int unsigned lo;
      sel = $urandom_range(0, 99);
      lo  = units > 2 ? units - 2 : 0;
      if (sel < 8)
         return '0;
      if (sel < 18)
         return RUN_W'($urandom_range(1024, 2047));
      if (sel < 30)
         return RUN_W'($urandom_range(lo, units + 2));
      if (units == 0)
         return RUN_W'($urandom_range(1, 8));
      return RUN_W'($urandom_range(1, units < 48 ? units : 48));
   endfunction

   // Bit positions: mostly inside the managed range, sometimes anywhere.
   function automatic logic [BIT_IDX_W-1:0] pick_bit_index(input int unsigned units);
      if (units != 0 && $urandom_range(0, 99) < 85)
         return BIT_IDX_W'($urandom_range(0, units - 1));
      return BIT_IDX_W'($urandom_range(0, 1023));
   endfunction

   // Mixed traffic: allocate-style sequences (scan, then claim the run bit by bit),
   // release sequences (free a stretch), and loose single requests as noise.
   task automatic run_random_traffic(input int unsigned item_budget);
      int unsigned  done;
      int unsigned  sel;
      int unsigned  units;
      int unsigned  k;
      int unsigned  span;
      logic [BIT_IDX_W-1:0] base;
      map_outcome_type got;
      req_code_type kind;
      done = 0;
      while (done < item_budget) begin
         back_to_back = ($urandom_range(0, 3) == 0);
         units = units_in_use();
         sel   = $urandom_range(0, 99);
         if (sel < 35) begin
            span = $urandom_range(1, 12);
            issue_request(REQ_SCAN, BIT_IDX_W'($urandom), 1'($urandom), RUN_W'(span), got);
            done++;
            if (got.found) begin
               // hold the run start; each write below overwrites got
               base = got.run_start;
               for (k = 0; k < span; k++)
                  issue_request(REQ_WRITE, base + BIT_IDX_W'(k), 1'b1,
                                RUN_W'($urandom), got);
               done += span;
            end
         end else if (sel < 48) begin
            span = $urandom_range(1, 16);
            base = pick_bit_index(units);
            for (k = 0; k < span; k++)
               issue_request(REQ_WRITE, base + BIT_IDX_W'(k), 1'b0, RUN_W'($urandom), got);
            done += span;
         end else begin
            sel = $urandom_range(0, 99);
            if (sel < 2)
               kind = REQ_CLEAR;
            else if (sel < 32)
               kind = REQ_TEST;
            else if (sel < 67)
               kind = REQ_WRITE;
            else
               kind = REQ_SCAN;
            issue_request(kind, kind == REQ_SCAN ? BIT_IDX_W'($urandom) : pick_bit_index(units),
                          ($urandom_range(0, 9) < 6),
                          kind == REQ_SCAN ? pick_run_length(units) : RUN_W'($urandom), got);
            done++;
         end
      end
   endtask

   // Fresh map after reset: all free, 128 bytes managed.
   task automatic test_reset_state();
      map_outcome_type got;
      issue_request(REQ_SCAN, '0, 1'b0, RUN_W'(0), got);
      issue_request(REQ_SCAN, '0, 1'b0, RUN_W'(1024), got);
      issue_request(REQ_SCAN, '1, 1'b1, RUN_W'(1025), got);
      issue_request(REQ_SCAN, '1, 1'b1, '1, got);
      issue_request(REQ_TEST, '1, 1'b0, '0, got);
   endtask

   // Single-bit writes and tests at both ends of the map, then a full clear.
   task automatic test_bit_access();
      map_outcome_type got;
      issue_request(REQ_WRITE, '0, 1'b1, '0, got);
      issue_request(REQ_WRITE, '1, 1'b1, '1, got);
      issue_request(REQ_TEST, '0, 1'b0, '0, got);
      issue_request(REQ_TEST, '1, 1'b0, '0, got);
      issue_request(REQ_SCAN, '0, 1'b0, RUN_W'(1), got);
      issue_request(REQ_WRITE, '0, 1'b0, '0, got);
      issue_request(REQ_CLEAR, '1, 1'b1, '1, got);
      issue_request(REQ_TEST, '1, 1'b0, '0, got);
   endtask

   // Register corners: one byte, zero bytes (everything inert), saturation above the
   // map size, an unmapped word, and stray upper data bits.
   task automatic test_config_edges();
      map_outcome_type got;
      wait_for_quiet();
      csr_write(BIU_ADDR, 32'd1);
      issue_request(REQ_WRITE, BIT_IDX_W'(8), 1'b1, '0, got);
      issue_request(REQ_TEST, BIT_IDX_W'(8), 1'b0, '0, got);
      issue_request(REQ_SCAN, '0, 1'b0, RUN_W'(9), got);
      issue_request(REQ_WRITE, BIT_IDX_W'(3), 1'b1, '0, got);
      wait_for_quiet();
      csr_write(BIU_ADDR, 32'd0);
      csr_write(UNMAPPED_ADDR, 32'h0000_0040);
      issue_request(REQ_TEST, BIT_IDX_W'(3), 1'b0, '0, got);
      issue_request(REQ_SCAN, '0, 1'b0, RUN_W'(1), got);
      issue_request(REQ_CLEAR, '0, 1'b0, '0, got);
      wait_for_quiet();
      csr_write(BIU_ADDR, 32'd200);
      issue_request(REQ_TEST, BIT_IDX_W'(3), 1'b0, '0, got);
      issue_request(REQ_SCAN, '0, 1'b0, RUN_W'(1), got);
      wait_for_quiet();
      csr_write(BIU_ADDR, 32'hFFFF_FF80);
   endtask

   // Random traffic over a series of map sizes, extremes included; the map carries
   // over between sizes so shrinking leaves stale bytes beyond the managed range.
   task automatic test_config_sweep();
      int unsigned sizes  [9] = '{128, 1, 2, 9, 127, 0, 255, 64, 0};
      int unsigned budget [9] = '{250, 60, 60, 80, 150, 20, 120, 80, 80};
      int          i;
      sizes[8] = $urandom_range(1, 128);
      for (i = 0; i < 9; i++) begin
         wait_for_quiet();
         csr_write(BIU_ADDR, CSR_DATA_W'(sizes[i]));
         map_sizes_run++;
         run_random_traffic(budget[i]);
      end
   endtask

   initial begin
      for (int b = 0; b < MAP_BYTES; b++)
         shadow_map[b] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_bit_access();
      test_config_edges();
      test_config_sweep();

      wait_for_quiet();
      $display("summary: %0d requests accepted, %0d result beats checked", requests_sent,
               beats_checked);
      $display("summary: directed corners plus random traffic over %0d map sizes",
               map_sizes_run);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
